@@ sv/tcq_pkg.sv @@
// Package: types and constants of the timer callout queue.
`timescale 1ns / 1ps
`default_nettype none
package tcq_pkg;
  localparam int unsigned DepthDefault = 16;

  typedef enum logic [1:0] {
    CmdSchedule = 2'd0,
    CmdCancel   = 2'd1,
    CmdTick     = 2'd2,
    CmdNone     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KindScheduled = 2'd0,
    KindRejected  = 2'd1,
    KindCancel    = 2'd2,
    KindTick      = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    StIdle, StSchedRd, StSchedCmp, StShiftUpRd, StShiftUpWr, StInsert,
    StCancRd, StCancCmp, StShiftDnRd, StShiftDnWr, StTickRd, StTickCmp,
    StHeadRd, StReport, StOut
  } state_e;

  typedef struct packed {
    logic [31:0] due;
    logic [7:0]  handler;
    logic [31:0] arg;
  } entry_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        found;
    logic        fired;
    logic [7:0]  fired_handler;
    logic [31:0] fired_arg;
    logic        last;
    logic        pending_valid;
    logic [15:0] ticks_to_next;
    logic [4:0]  entry_count;
  } result_t;

  function automatic logic [15:0] clamp_ticks(input logic [31:0] d);
    logic [15:0] r;
    if (d[31]) r = '0;
    else if (d[31:16] != '0) r = 16'hFFFF;
    else r = d[15:0];
    return r;
  endfunction
endpackage
`default_nettype wire

@@ sv/tcq_if.sv @@
// Interfaces: command and result channels.
`timescale 1ns / 1ps
`default_nettype none
interface tcq_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  handler_id;
  logic [31:0] arg;
  logic [15:0] delay;
  modport source (output valid, cmd, handler_id, arg, delay, input ready);
  modport sink (input valid, cmd, handler_id, arg, delay, output ready);
endinterface

interface tcq_res_if;
  logic                   valid;
  logic                   ready;
  tcq_pkg::result_t       res;
  modport source (output valid, res, input ready);
  modport sink (input valid, res, output ready);
endinterface
`default_nettype wire

@@ sv/tcq_mem.sv @@
// Entry memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module tcq_mem #(
  parameter int unsigned DEPTH = tcq_pkg::DepthDefault,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire tcq_pkg::entry_t wdata_i,
  input  wire logic [AW-1:0]   raddr_i,
  output tcq_pkg::entry_t      rdata_o
);
  tcq_pkg::entry_t mem_q [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ sv/tcq_ctrl.sv @@
// Sequencer: insert, cancel and expiry walks over the entry memory.
`timescale 1ns / 1ps
`default_nettype none
module tcq_ctrl #(
  parameter int unsigned DEPTH = tcq_pkg::DepthDefault,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  tcq_cmd_if.sink              cmd_if,
  tcq_res_if.source            res_if,
  output logic                 we_o,
  output logic [AW-1:0]        waddr_o,
  output tcq_pkg::entry_t      wdata_o,
  output logic [AW-1:0]        raddr_o,
  input  wire tcq_pkg::entry_t rdata_i
);
  tcq_pkg::state_e state_q, state_d;
  logic [CW-1:0] fill_q, fill_d, idx_q, idx_d;
  logic [31:0] now_q, now_d;
  logic [1:0] cmd_q, cmd_d;
  logic [7:0] hnd_q, hnd_d;
  logic [31:0] arg_q, arg_d;
  logic [15:0] dly_q, dly_d;
  logic [CW-1:0] pos_q, pos_d;
  tcq_pkg::result_t res_q, res_d;
  logic fired_q, fired_d;
  logic [31:0] dd, offs;

  assign dd = rdata_i.due - now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcq_pkg::StIdle;
      fill_q <= '0;
      now_q <= '0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      now_q <= now_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; cmd_q <= cmd_d; hnd_q <= hnd_d; arg_q <= arg_d;
    dly_q <= dly_d; pos_q <= pos_d; res_q <= res_d;
    fired_q <= fired_d;
  end

  always_comb begin
    state_d = state_q; fill_d = fill_q; now_d = now_q; idx_d = idx_q;
    cmd_d = cmd_q; hnd_d = hnd_q; arg_d = arg_q; dly_d = dly_q;
    pos_d = pos_q; res_d = res_q; fired_d = fired_q;
    we_o = 1'b0; waddr_o = idx_q[AW-1:0]; raddr_o = idx_q[AW-1:0];
    wdata_o = rdata_i;
    offs = '0;
    cmd_if.ready = (state_q == tcq_pkg::StIdle);
    res_if.valid = (state_q == tcq_pkg::StOut);
    res_if.res = res_q;
    unique case (state_q)
      tcq_pkg::StIdle: begin
        if (cmd_if.valid) begin
          cmd_d = cmd_if.cmd; hnd_d = cmd_if.handler_id;
          arg_d = cmd_if.arg; dly_d = cmd_if.delay;
          idx_d = '0; fired_d = 1'b0;
          res_d = '0; res_d.last = 1'b1;
          unique case (tcq_pkg::cmd_e'(cmd_if.cmd))
            tcq_pkg::CmdSchedule: begin
              if (fill_q == CW'(DEPTH)) begin
                res_d.result_kind = tcq_pkg::KindRejected;
                state_d = tcq_pkg::StHeadRd;
              end else state_d = tcq_pkg::StSchedRd;
            end
            tcq_pkg::CmdCancel: state_d = tcq_pkg::StCancRd;
            tcq_pkg::CmdTick: begin
              now_d = now_q + 32'd1;
              state_d = tcq_pkg::StTickRd;
            end
            default: state_d = tcq_pkg::StIdle;
          endcase
        end
      end
      tcq_pkg::StSchedRd: begin
        if (idx_q == fill_q) begin
          state_d = tcq_pkg::StInsert;
        end else state_d = tcq_pkg::StSchedCmp;
      end
      tcq_pkg::StSchedCmp: begin
        if (dd <= {16'd0, dly_q}) begin
          idx_d = idx_q + 1'b1;
          state_d = tcq_pkg::StSchedRd;
        end else begin
          pos_d = idx_q;
          idx_d = fill_q - 1'b1;
          state_d = tcq_pkg::StShiftUpRd;
        end
      end
      tcq_pkg::StShiftUpRd: state_d = tcq_pkg::StShiftUpWr;
      tcq_pkg::StShiftUpWr: begin
        we_o = 1'b1;
        waddr_o = AW'(idx_q + 1'b1);
        if (idx_q == pos_q) state_d = tcq_pkg::StInsert;
        else begin
          idx_d = idx_q - 1'b1;
          state_d = tcq_pkg::StShiftUpRd;
        end
        if (idx_q == pos_q) idx_d = idx_q;
      end
      tcq_pkg::StInsert: begin
        we_o = 1'b1;
        wdata_o.due = now_q + {16'd0, dly_q};
        wdata_o.handler = hnd_q;
        wdata_o.arg = arg_q;
        fill_d = fill_q + 1'b1;
        res_d.result_kind = tcq_pkg::KindScheduled;
        state_d = tcq_pkg::StHeadRd;
        idx_d = '0;
      end
      tcq_pkg::StCancRd: begin
        if (idx_q == fill_q) begin
          res_d.result_kind = tcq_pkg::KindCancel;
          state_d = tcq_pkg::StHeadRd;
          idx_d = '0;
        end else state_d = tcq_pkg::StCancCmp;
      end
      tcq_pkg::StCancCmp: begin
        if (rdata_i.handler == hnd_q && rdata_i.arg == arg_q) begin
          state_d = tcq_pkg::StShiftDnRd;
          idx_d = idx_q + 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = tcq_pkg::StCancRd;
        end
      end
      tcq_pkg::StShiftDnRd: begin
        if (idx_q >= fill_q) begin
          fill_d = fill_q - 1'b1;
          idx_d = '0;
          if (cmd_q == tcq_pkg::CmdCancel) begin
            res_d.result_kind = tcq_pkg::KindCancel;
            res_d.found = 1'b1;
            state_d = tcq_pkg::StHeadRd;
          end else state_d = tcq_pkg::StHeadRd;
        end else state_d = tcq_pkg::StShiftDnWr;
      end
      tcq_pkg::StShiftDnWr: begin
        we_o = 1'b1;
        waddr_o = AW'(idx_q - 1'b1);
        idx_d = idx_q + 1'b1;
        state_d = tcq_pkg::StShiftDnRd;
      end
      tcq_pkg::StTickRd: begin
        if (fill_q == '0) begin
          res_d.result_kind = tcq_pkg::KindTick;
          state_d = tcq_pkg::StHeadRd;
        end else state_d = tcq_pkg::StTickCmp;
      end
      tcq_pkg::StTickCmp: begin
        if (dd == '0 || dd[31]) begin
          fired_d = 1'b1;
          res_d.fired = 1'b1;
          res_d.fired_handler = rdata_i.handler;
          res_d.fired_arg = rdata_i.arg;
          idx_d = CW'(1);
          state_d = tcq_pkg::StShiftDnRd;
        end else begin
          res_d.result_kind = tcq_pkg::KindTick;
          state_d = tcq_pkg::StHeadRd;
        end
      end
      tcq_pkg::StHeadRd: begin
        idx_d = '0;
        state_d = tcq_pkg::StReport;
      end
      tcq_pkg::StReport: begin
        res_d.pending_valid = (fill_q != '0);
        res_d.entry_count = 5'(fill_q);
        res_d.ticks_to_next = (fill_q != '0) ? tcq_pkg::clamp_ticks(dd) : '0;
        if (cmd_q == tcq_pkg::CmdTick) begin
          res_d.result_kind = tcq_pkg::KindTick;
          offs = dd;
          res_d.last = !(fired_q && fill_q != '0 && (offs == '0 || offs[31]));
        end
        state_d = tcq_pkg::StOut;
      end
      tcq_pkg::StOut: begin
        if (res_if.ready) begin
          if (cmd_q == tcq_pkg::CmdTick && !res_q.last) begin
            res_d = '0; fired_d = 1'b0;
            state_d = tcq_pkg::StTickRd;
          end else state_d = tcq_pkg::StIdle;
        end
      end
      default: state_d = tcq_pkg::StIdle;
    endcase
  end
endmodule
`default_nettype wire

@@ sv/timer_callout_queue.sv @@
// Top level: sorted timer callout queue.
// Usage:
//   cmd_if carries schedule, cancel and tick items; res_if returns results.
//   Entries live in one synchronous memory of DEPTH rows (due, handler, arg),
//   walked row by row by a sequencer.
//   Schedule: walks the queue and appends behind the queued entries, or
//   inserts ahead of the first entry due later than the new one.
//   Cancel: searches for an entry matching handler and arg and shifts the
//   later ones down. Tick: advances the time and removes each fired entry
//   from the head; a quiet tick reports with no entry fired.
//   Schedule and cancel time is set by the walk over the memory's single
//   read port; a tick pays for a walk per fired entry. One item is
//   processed at a time; the next is taken only once the sequencer is idle.
//   Each result is held in an output register until res_if.ready; the
//   sequencer waits while the receiver stalls. A tick that fires several
//   entries emits them earliest first, last set on the final one.
//   Reset clears current time and fill count; memory contents need no clear.
//   Command code 3 is dropped with no result.
`timescale 1ns / 1ps
`default_nettype none
module timer_callout_queue #(
  parameter int unsigned DEPTH = tcq_pkg::DepthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tcq_cmd_if.sink   cmd_if,
  tcq_res_if.source res_if
);
  localparam int unsigned AW = $clog2(DEPTH);
  logic we;
  logic [AW-1:0] waddr, raddr;
  tcq_pkg::entry_t wdata, rdata;

  tcq_mem #(.DEPTH(DEPTH)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  tcq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i, .rst_ni, .cmd_if, .res_if,
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata), .raddr_o(raddr), .rdata_i(rdata)
  );
endmodule
`default_nettype wire
